// File: hw/rtl/mdc_pkg.sv
// shared types, register codes and sine helper for the chorus block
`default_nettype none

package mdc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_AMOUNT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_AMOUNT   = 4'd3;

  // register widths and reset values
  localparam int PHASE_STEP_W = 24;
  localparam int BASE_DELAY_W = 20;
  localparam int DEPTH_W      = 19;
  localparam int MIX_W        = 17;
  localparam int SINE_W       = 16;

  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST = 24'd89478;
  localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_RST = 20'd184320;
  localparam logic [DEPTH_W-1:0]      DEPTH_RST      = 19'd61440;
  localparam logic [MIX_W-1:0]        MIX_RST        = 17'd32768;
  localparam logic [MIX_W-1:0]        MIX_FULL       = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINE,
    ST_SCALE,
    ST_DELAY,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_INTERP,
    ST_MIX,
    ST_OUT
  } mdc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sine;
    logic scale;
    logic delay;
    logic addr;
    logic rd0;
    logic rd1;
    logic interp;
    logic mix;
    logic fin;
  } mdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;
  } mdc_status_t;

  // quarter-wave polynomial sine of a 16-bit phase, Q1.15
  function automatic logic signed [SINE_W-1:0] sine_of_phase(input logic [15:0] t);
    logic [1:0] q;
    longint     u;
    longint     x;
    longint     x2;
    longint     a;
    longint     s;
    q = t[15:14];
    u = longint'(t[13:0]);
    if (q[0]) begin
      u = 16384 - u;
    end
    x  = u * 2;
    x2 = (x * x) >>> 15;
    a  = 21024 - ((2320 * x2) >>> 15);
    a  = 51472 - ((a * x2) >>> 15);
    s  = (a * x) >>> 15;
    if (s > 32767) begin
      s = 32767;
    end
    if (q[1]) begin
      s = -s;
    end
    return SINE_W'(s);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mdc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mdc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mdc_ctrl.sv
// sequencing state machine for the chorus datapath
`default_nettype none

module mdc_ctrl
  import mdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mdc_status_t stat,
  output mdc_cmd_t         cmd
);

  mdc_state_t state_r;
  mdc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SINE;
      ST_SINE:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_DELAY;
      ST_DELAY:  state_nxt = ST_ADDR;
      ST_ADDR:   state_nxt = ST_RD0;
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_MIX;
      ST_MIX:    state_nxt = ST_OUT;
      ST_OUT:    if (!stat.out_blocked) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SINE:   cmd.sine   = 1'b1;
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_DELAY:  cmd.delay  = 1'b1;
      ST_ADDR:   cmd.addr   = 1'b1;
      ST_RD0:    cmd.rd0    = 1'b1;
      ST_RD1:    cmd.rd1    = 1'b1;
      ST_INTERP: cmd.interp = 1'b1;
      ST_MIX:    cmd.mix    = 1'b1;
      ST_OUT:    cmd.fin    = !stat.out_blocked;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/mdc_datapath.sv
// chorus datapath: lfo, delay computation, delay line, interpolation and mix
`default_nettype none

module mdc_datapath
  import mdc_pkg::*;
#(
  parameter int DELAY_DEPTH  = 4096,
  parameter int SAMPLE_BITS  = 24,
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mdc_cmd_t                      cmd,
  output mdc_status_t                        stat,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  input  wire logic                          cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = $clog2(SINE_ENTRIES);
  localparam int CW = (AW + 9 > 22) ? AW + 9 : 22;
  localparam int RW = AW + 10;

  localparam logic [SW:0]             SE_V     = (SW + 1)'(SINE_ENTRIES);
  localparam logic signed [CW-1:0]    DLY_MIN  = CW'(256);
  localparam logic signed [CW-1:0]    DLY_MAX  = CW'((DELAY_DEPTH - 2) * 256);
  localparam logic signed [RW-1:0]    LINE_Q8  = RW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0]           LAST_IDX = AW'(DELAY_DEPTH - 1);
  localparam logic signed [SB+3:0]    SMAX     = (SB + 4)'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [SB+3:0]    SMIN     = -SMAX - (SB + 4)'(1);
  localparam logic signed [SB+19:0]   ROUND    = (SB + 20)'(32768);

  typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_ENTRIES];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    longint    t;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t      = (longint'(k) * 65536) / SINE_ENTRIES;
      lut[k] = sine_of_phase(16'(t));
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // configuration
  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic [BASE_DELAY_W-1:0] base_r;
  logic [DEPTH_W-1:0]      depth_r;
  logic [MIX_W-1:0]        mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
      base_r       <= BASE_DELAY_RST;
      depth_r      <= DEPTH_RST;
      mix_r        <= MIX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PHASE_STEP:   phase_step_r <= cfg_data[PHASE_STEP_W-1:0];
        CFG_BASE_DELAY:   base_r       <= cfg_data[BASE_DELAY_W-1:0];
        CFG_DEPTH_AMOUNT: depth_r      <= cfg_data[DEPTH_W-1:0];
        CFG_MIX_AMOUNT:   mix_r        <= cfg_data[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [31:0]   phase_r;
  logic [AW-1:0] wr_idx_r;
  logic          wrapped_r;
  logic          out_valid_r;

  // payload registers
  logic signed [SB-1:0]     dry_r;
  logic [SW-1:0]            idx_r;
  logic signed [SINE_W-1:0] sine_r;
  logic signed [35:0]       swing_r;
  logic [AW+7:0]            delay_r;
  logic [AW-1:0]            i0_r;
  logic [AW-1:0]            i1_r;
  logic [7:0]               frac_r;
  logic                     v0_r;
  logic                     v1_r;
  logic signed [SB-1:0]     s0_r;
  logic signed [SB-1:0]     wet_r;
  logic signed [SB+18:0]    mixp_r;
  logic signed [SB-1:0]     out_r;

  // lfo table index
  logic [32+SW:0] idx_prod;
  assign idx_prod = (33 + SW)'(phase_r) * (33 + SW)'(SE_V);

  // delay clamp
  logic signed [CW-1:0] dsum;
  logic signed [CW-1:0] dclamp;
  assign dsum   = CW'($signed({1'b0, base_r})) + CW'(swing_r >>> 15);
  assign dclamp = (dsum < DLY_MIN) ? DLY_MIN : ((dsum > DLY_MAX) ? DLY_MAX : dsum);

  // read position
  logic signed [RW-1:0] rp_raw;
  logic signed [RW-1:0] rp;
  logic [AW-1:0]        i0;
  assign rp_raw = $signed({2'b00, wr_idx_r, 8'h00}) - $signed({2'b00, delay_r});
  assign rp     = (rp_raw < 0) ? rp_raw + LINE_Q8 : rp_raw;
  assign i0     = rp[AW+7:8];

  // delay line
  logic [AW-1:0] raddr;
  logic [SB-1:0] rdata;
  logic          ram_we;

  assign raddr  = cmd.rd0 ? i0_r : i1_r;
  assign ram_we = cmd.rd1;

  mdc_ram #(
    .WIDTH(SB),
    .DEPTH(DELAY_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(dry_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // entries not yet written since reset read as zero
  logic rd_written;
  assign rd_written = wrapped_r || (raddr < wr_idx_r);

  // interpolation: s0*256 + (s1 - s0)*frac
  logic signed [SB-1:0]  s1;
  logic signed [SB:0]    idiff;
  logic signed [SB+9:0]  iprod;
  logic signed [SB+10:0] isum;
  assign s1    = v1_r ? $signed(rdata) : '0;
  assign idiff = (SB + 1)'(s1) - (SB + 1)'(s0_r);
  assign iprod = idiff * $signed({1'b0, frac_r});
  assign isum  = $signed({{3{s0_r[SB-1]}}, s0_r, 8'h00}) + (SB + 11)'(iprod);

  // mix: dry*65536 + (wet - dry)*mix
  logic [MIX_W-1:0]      mix_sat;
  logic signed [SB:0]    mdiff;
  logic signed [SB+19:0] acc;
  logic signed [SB+3:0]  acc_sh;
  logic signed [SB-1:0]  acc_sat;
  assign mix_sat = (mix_r > MIX_FULL) ? MIX_FULL : mix_r;
  assign mdiff   = (SB + 1)'(wet_r) - (SB + 1)'(dry_r);
  assign acc     = $signed({{4{dry_r[SB-1]}}, dry_r, 16'h0000}) + (SB + 20)'(mixp_r) + ROUND;
  assign acc_sh  = acc[SB+19:16];
  assign acc_sat = (acc_sh > SMAX) ? SB'(SMAX) : ((acc_sh < SMIN) ? SB'(SMIN) : SB'(acc_sh));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      wr_idx_r    <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        phase_r <= phase_r + 32'(phase_step_r);
      end
      if (cmd.rd1) begin
        if (wr_idx_r == LAST_IDX) begin
          wr_idx_r  <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wr_idx_r <= wr_idx_r + 1'b1;
        end
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry_r <= sample_in;
      idx_r <= idx_prod[32+SW-1:32];
    end
    if (cmd.sine) begin
      sine_r <= SINE_LUT[idx_r];
    end
    if (cmd.scale) begin
      swing_r <= $signed({1'b0, depth_r}) * sine_r;
    end
    if (cmd.delay) begin
      delay_r <= dclamp[AW+7:0];
    end
    if (cmd.addr) begin
      i0_r   <= i0;
      i1_r   <= (i0 == LAST_IDX) ? '0 : i0 + 1'b1;
      frac_r <= rp[7:0];
    end
    if (cmd.rd0) begin
      v0_r <= rd_written;
    end
    if (cmd.rd1) begin
      v1_r <= rd_written;
      s0_r <= v0_r ? $signed(rdata) : '0;
    end
    if (cmd.interp) begin
      wet_r <= isum[SB+7:8];
    end
    if (cmd.mix) begin
      mixp_r <= mdiff * $signed({1'b0, mix_sat});
    end
    if (cmd.fin) begin
      out_r <= acc_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign sample_out       = out_r;
  assign stat.out_blocked = out_valid_r && !out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/modulated_delay_chorus.sv
// chorus effect top level: sine lfo modulating a fractional delay line
// usage:
//  - in_valid/in_ready carry one signed audio sample per transfer (in_sample_in)
//  - out_valid/out_ready carry the mixed sample (out_sample_out), one per input
//  - cfg_valid/cfg_ready write phase step, base delay, depth and mix by index;
//    cfg_ready is always high, write only while no sample is in flight,
//    indexes past the four registers are ignored
//  - after the input transfer the controller walks the lfo lookup, the delay
//    multiply and clamp, two reads of the single delay line read port,
//    interpolation, the mix multiply and the output step in turn, and
//    out_valid rises once the result is registered; input is taken only in idle
//  - the result sits in an output register, so the next sample is taken
//    while it waits; a stalled receiver holds the following result in the
//    last step until the output register frees up
//  - reset clears lfo phase, write pointer and registers to defaults; no
//    clearing pass runs over the delay line, a fill flag makes entries not
//    written since reset read as zero, so samples are taken right away
`default_nettype none

module modulated_delay_chorus
  import mdc_pkg::*;
#(
  parameter int DELAY_DEPTH  = 4096,
  parameter int SAMPLE_BITS  = 24,
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input sample channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  mdc_cmd_t    cmd;
  mdc_status_t stat;
  logic        cfg_we;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: one step of the sample's work per state
  mdc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic, lfo table, delay line and output register
  mdc_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .sample_in (in_sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(out_sample_out),
    .cfg_valid (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// File: tb/sv/modulated_delay_chorus_test.sv
// self-checking testbench for the modulated delay chorus block
`timescale 1ns / 100ps

module modulated_delay_chorus_test
  import mdc_pkg::*;
();

  localparam int SMP_W          = 24;
  localparam int LINE_DEPTH     = 4096;
  localparam int SINE_AW        = 10;
  localparam int SINE_N         = 1 << SINE_AW;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 160;
  localparam int SETTLE_CYCLES  = 40;

  localparam longint SMP_MAX = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;

  // indexes past the four registers, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'd15;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic signed [SMP_W-1:0] out_sample_out;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data     = '0;

  always #5 clk = ~clk;

  modulated_delay_chorus u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // chorus predictor: own copy of the registers, the delay line and the lfo
  // ---------------------------------------------------------------------------
  logic [PHASE_STEP_W-1:0] lfo_step     = PHASE_STEP_RST;
  logic [BASE_DELAY_W-1:0] centre_delay = BASE_DELAY_RST;
  logic [DEPTH_W-1:0]      delay_swing  = DEPTH_RST;
  logic [MIX_W-1:0]        wet_share    = MIX_RST;
  logic signed [SMP_W-1:0] delay_line [LINE_DEPTH];
  logic [11:0]             line_wr_ptr  = '0;
  logic [31:0]             lfo_acc      = '0;
  longint                  sine_lut [SINE_N];

  // quarter-wave polynomial sine, Q1.15, of table entry k
  function automatic longint lfo_sine_entry(input int k);
    longint t;
    longint u;
    longint x;
    longint x2;
    longint a;
    longint s;
    int     quad;
    t    = (longint'(k) * 65536) / SINE_N;
    quad = int'((t >> 14) & 3);
    u    = t & 16383;
    if (quad % 2 == 1) begin
      u = 16384 - u;
    end
    x  = u * 2;
    x2 = (x * x) >>> 15;
    a  = 21024 - ((2320 * x2) >>> 15);
    a  = 51472 - ((a * x2) >>> 15);
    s  = (a * x) >>> 15;
    if (s > 32767) begin
      s = 32767;
    end
    return (quad >= 2) ? -s : s;
  endfunction

  // one sample through the chorus: returns the mixed output, updates the state
  function automatic logic signed [SMP_W-1:0] chorus_predict(input logic signed [SMP_W-1:0] dry_in);
    longint dry;
    longint sine;
    longint delay;
    longint rd_pos;
    longint frac;
    longint wet;
    longint mix;
    longint acc;
    int     tap0;
    int     tap1;
    dry   = longint'(dry_in);
    sine  = sine_lut[lfo_acc >> (32 - SINE_AW)];
    delay = longint'(centre_delay) + ((longint'(delay_swing) * sine) >>> 15);
    // delay clamped to one sample .. line length minus two
    if (delay < 256) begin
      delay = 256;
    end
    if (delay > longint'(LINE_DEPTH - 2) * 256) begin
      delay = longint'(LINE_DEPTH - 2) * 256;
    end
    // read position behind the write pointer wraps around the line
    rd_pos = longint'(line_wr_ptr) * 256 - delay;
    if (rd_pos < 0) begin
      rd_pos = rd_pos + longint'(LINE_DEPTH) * 256;
    end
    tap0 = int'((rd_pos >> 8) % LINE_DEPTH);
    tap1 = (tap0 + 1) % LINE_DEPTH;
    frac = rd_pos & 255;
    wet  = (longint'(delay_line[tap0]) * (256 - frac) +
            longint'(delay_line[tap1]) * frac) >>> 8;
    delay_line[line_wr_ptr] = dry_in;
    line_wr_ptr = line_wr_ptr + 12'd1;
    lfo_acc     = lfo_acc + 32'(lfo_step);
    // wet share above full saturates to fully wet
    mix = (wet_share > MIX_FULL) ? 65536 : longint'(wet_share);
    acc = (dry * (65536 - mix) + wet * mix + 32768) >>> 16;
    if (acc > SMP_MAX) begin
      acc = SMP_MAX;
    end
    if (acc < SMP_MIN) begin
      acc = SMP_MIN;
    end
    return SMP_W'(acc);
  endfunction

  function automatic void chorus_set_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PHASE_STEP:   lfo_step     = data[PHASE_STEP_W-1:0];
      CFG_BASE_DELAY:   centre_delay = data[BASE_DELAY_W-1:0];
      CFG_DEPTH_AMOUNT: delay_swing  = data[DEPTH_W-1:0];
      CFG_MIX_AMOUNT:   wet_share    = data[MIX_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // expected output samples and checking
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] expected_samples [$];
  int errors       = 0;
  int in_gap_pct   = 0;
  int out_stall_pct = 0;
  int idle_cycles  = 0;

  task automatic flag_sample(input string what, input logic signed [SMP_W-1:0] want,
                             input logic signed [SMP_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // receiver: random stalls, compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        flag_sample("sample_out with nothing pending", 'x, out_sample_out);
      end else if (out_sample_out !== expected_samples[0]) begin
        flag_sample("sample_out mismatch", expected_samples.pop_front(), out_sample_out);
      end else begin
        void'(expected_samples.pop_front());
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // wait until every pending result has come back, input side quiet
  task automatic wait_for_drain();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // register write, only with the block idle; valid stays high for a
  // back-to-back write and is lowered by whoever drives next
  task automatic write_chorus_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    chorus_set_reg(idx, data);
  endtask

  // one sample transfer; a typed expectation replaces the predicted one
  task automatic send_sample(input logic [SMP_W-1:0] raw, input bit typed,
                             input logic [SMP_W-1:0] want);
    logic signed [SMP_W-1:0] predicted;
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    while ($urandom_range(0, 99) < in_gap_pct) begin
      if (in_valid) begin
        in_valid <= 1'b0;
      end
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= raw;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = chorus_predict(raw);
    expected_samples.push_back(typed ? want : predicted);
  endtask

  task automatic pick_setting(input int ph);
    logic [CFG_DATA_W-1:0] step_v;
    logic [CFG_DATA_W-1:0] base_v;
    logic [CFG_DATA_W-1:0] swing_v;
    logic [CFG_DATA_W-1:0] mix_v;
    case (ph)
      0: begin
        step_v = 24'hFFFFFF; base_v = 24'd256; swing_v = 24'h07FFFF; mix_v = 24'd65536;
      end
      1: begin
        step_v = '0; base_v = 24'h0FFFFF; swing_v = '0; mix_v = '0;
      end
      2: begin
        step_v  = PHASE_STEP_RST;
        base_v  = CFG_DATA_W'(BASE_DELAY_RST);
        swing_v = CFG_DATA_W'(DEPTH_RST);
        mix_v   = CFG_DATA_W'(MIX_RST);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: step_v = '0;
          1: step_v = 24'hFFFFFF;
          2: step_v = CFG_DATA_W'($urandom_range(0, 300000));
          default: step_v = CFG_DATA_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0: base_v = CFG_DATA_W'($urandom_range(256, 1048064));
          1: base_v = CFG_DATA_W'($urandom_range(1048064, 1048575));
          2: base_v = CFG_DATA_W'($urandom_range(256, 60000));
          default: base_v = CFG_DATA_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0: swing_v = 24'd524032;
          1: swing_v = CFG_DATA_W'($urandom_range(0, 100000));
          default: swing_v = CFG_DATA_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0: mix_v = CFG_DATA_W'($urandom_range(65537, 131071));
          1: mix_v = CFG_DATA_W'($urandom());
          default: mix_v = CFG_DATA_W'($urandom_range(0, 65536));
        endcase
      end
    endcase
    write_chorus_reg(CFG_PHASE_STEP, step_v);
    write_chorus_reg(CFG_BASE_DELAY, base_v);
    write_chorus_reg(CFG_DEPTH_AMOUNT, swing_v);
    write_chorus_reg(CFG_MIX_AMOUNT, mix_v);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: register writes and samples, typed results only where the
  // delay line is still known to be empty or a one-sample delay is set
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    logic [SMP_W-1:0]      want;
  } dir_row_t;

  localparam int DIR_ROWS = 36;
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    dir_rows = '{
      // default half mix, empty line: output is half the dry sample, rounded
      '{1'b0, '0, 24'h7FFFFF, 1'b1, 24'h400000},
      '{1'b0, '0, 24'h800000, 1'b1, 24'hC00000},
      '{1'b0, '0, 24'h000000, 1'b1, 24'h000000},
      '{1'b0, '0, 24'h000001, 1'b1, 24'h000001},
      '{1'b0, '0, 24'hFFFFFF, 1'b1, 24'h000000},
      // fully dry
      '{1'b1, CFG_MIX_AMOUNT, 24'd0, 1'b0, '0},
      '{1'b0, '0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
      '{1'b0, '0, 24'h800000, 1'b1, 24'h800000},
      '{1'b0, '0, 24'h555555, 1'b1, 24'h555555},
      '{1'b0, '0, 24'hAAAAAA, 1'b1, 24'hAAAAAA},
      // fully wet, read position wraps into the untouched end of the line
      '{1'b1, CFG_MIX_AMOUNT, 24'd65536, 1'b0, '0},
      '{1'b0, '0, 24'h003039, 1'b1, 24'h000000},
      // wet share above full saturates
      '{1'b1, CFG_MIX_AMOUNT, 24'h01FFFF, 1'b0, '0},
      '{1'b0, '0, 24'hFFFCF7, 1'b1, 24'h000000},
      // writes to unused indexes change nothing
      '{1'b1, CFG_IDX_UNUSED_LO, 24'hFFFFFF, 1'b0, '0},
      '{1'b1, CFG_IDX_UNUSED_HI, 24'h123456, 1'b0, '0},
      '{1'b0, '0, 24'h0010E1, 1'b1, 24'h000000},
      // zero delay clamps to one sample: output is the previous input
      '{1'b1, CFG_BASE_DELAY, 24'd0, 1'b0, '0},
      '{1'b1, CFG_DEPTH_AMOUNT, 24'd0, 1'b0, '0},
      '{1'b0, '0, 24'h000063, 1'b1, 24'h0010E1},
      '{1'b0, '0, 24'hFFFFFB, 1'b1, 24'h000063},
      // base and depth beyond range, clamp at the far end of the line
      '{1'b1, CFG_BASE_DELAY, 24'h0FFFFF, 1'b0, '0},
      '{1'b1, CFG_DEPTH_AMOUNT, 24'h07FFFF, 1'b0, '0},
      '{1'b0, '0, 24'h7FFFFF, 1'b0, '0},
      '{1'b0, '0, 24'h800000, 1'b0, '0},
      // fastest lfo, minimum base with maximum swing
      '{1'b1, CFG_PHASE_STEP, 24'hFFFFFF, 1'b0, '0},
      '{1'b1, CFG_MIX_AMOUNT, 24'd32768, 1'b0, '0},
      '{1'b1, CFG_BASE_DELAY, 24'd256, 1'b0, '0},
      '{1'b1, CFG_DEPTH_AMOUNT, 24'd524032, 1'b0, '0},
      '{1'b0, '0, 24'h123456, 1'b0, '0},
      '{1'b0, '0, 24'hEDCBA9, 1'b0, '0},
      '{1'b0, '0, 24'h400000, 1'b0, '0},
      // frozen lfo, maximum stated base
      '{1'b1, CFG_PHASE_STEP, 24'd0, 1'b0, '0},
      '{1'b1, CFG_BASE_DELAY, 24'd1048064, 1'b0, '0},
      '{1'b0, '0, 24'h3FFFFF, 1'b0, '0},
      '{1'b0, '0, 24'hC00001, 1'b0, '0}
    };
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SMP_W-1:0] raw;
    for (int k = 0; k < SINE_N; k++) begin
      sine_lut[k] = lfo_sine_entry(k);
    end
    foreach (delay_line[i]) begin
      delay_line[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].is_cfg) begin
        write_chorus_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_sample(dir_rows[r].data, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random part: a new setting and idle pattern per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 86; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 86; end
        default: begin in_gap_pct = 21; out_stall_pct = 21; end
      endcase
      pick_setting(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: raw = 24'h7FFFFF;
          1: raw = 24'h800000;
          2: raw = SMP_W'($urandom_range(0, 511)) - 24'd256;
          default: raw = SMP_W'($urandom());
        endcase
        send_sample(raw, 1'b0, '0);
      end
    end

    wait_for_drain();
    if (cfg_valid) begin
      cfg_valid <= 1'b0;
    end
    // settle time for any stray result
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      errors += expected_samples.size();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mdc_pkg.sv
hw/rtl/mdc_ram.sv
hw/rtl/mdc_ctrl.sv
hw/rtl/mdc_datapath.sv
hw/rtl/modulated_delay_chorus.sv
tb/sv/modulated_delay_chorus_test.sv
